>>> rtl/swap_inversion_tracker_macros.svh
// Assertion macros used by the bound checker (sit_sva).
`ifndef SWAP_INVERSION_TRACKER_MACROS_SVH
`define SWAP_INVERSION_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swap_inversion_tracker: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swap_inversion_tracker: assertion failed");

`endif

>>> rtl/sit_pkg.sv
`timescale 1ns / 1ps
package sit_pkg;
  localparam int unsigned DefDepth = 1024;
  localparam int unsigned PosW     = 10;
  localparam int unsigned CountW   = 19;
endpackage

>>> rtl/swap_inversion_tracker.sv
`timescale 1ns / 1ps
// swap_inversion_tracker: keeps a permutation (identity after reset) and its
// running inversion count; each item swaps two positions and yields the count.
//
// Command channel: first_position_i / second_position_i are taken at a rising
// edge with start high and busy low. busy stays high while the item works.
// Result channel: inversion_total_o is valid for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall it, so nothing waits on it.
//
// Sequence: an item with lo < hi < DEPTH reads store[lo] and store[hi], scans
// the entries between them, writes the swapped pair, then strobes. The scan
// reads one stored entry per cycle through the single read port of the
// permutation RAM, whose registered read makes each compare trail its address.
// Equal positions or a position at or past DEPTH leave the state unchanged and
// return the count. A new item may be started in the cycle the strobe shows.
//
// Reset: the count clears at once; then a fill pass writes entry i = i, one
// entry per cycle over all DEPTH entries, with busy held high until it finishes.
module swap_inversion_tracker
  import sit_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [PosW-1:0]   first_position_i,
  input  logic [PosW-1:0]   second_position_i,
  output logic              result_valid_o,
  output logic [CountW-1:0] inversion_total_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDLO  = 3'd2;
  localparam logic [2:0] S_RDHI  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SWAP1 = 3'd5;
  localparam logic [2:0] S_SWAP2 = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;        // fill index, then scan address
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]     vlo_q, vlo_d, vhi_q, vhi_d;
  logic              cap_hi_q, cap_hi_d;  // rdata holds store[hi]
  logic              cmp_q, cmp_d;        // rdata holds a scanned entry
  logic [CountW-1:0] cnt_q, cnt_d;        // entries strictly between
  logic [CountW-1:0] tot_q, tot_d;
  logic              valid_q, valid_d;

  logic              accept;
  logic [PosW-1:0]   p_lo, p_hi;
  logic              in_range;
  logic              lo_lt_hi;
  logic [AW-1:0]     vmin, vmax;
  logic [CountW-1:0] step;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  sit_ram #(
    .Width (AW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = start && !busy;
  assign p_lo     = (first_position_i < second_position_i) ? first_position_i
                                                           : second_position_i;
  assign p_hi     = (first_position_i < second_position_i) ? second_position_i
                                                           : first_position_i;
  assign in_range = (32'(p_hi) < DEPTH) && (p_lo != p_hi);

  // Swapped values ordered; direction of the count change follows them.
  assign lo_lt_hi = vlo_q < vhi_q;
  assign vmin     = lo_lt_hi ? vlo_q : vhi_q;
  assign vmax     = lo_lt_hi ? vhi_q : vlo_q;
  assign step     = {cnt_q[CountW-2:0], 1'b1};

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    vlo_d    = vlo_q;
    vhi_d    = cap_hi_q ? ram_rdata : vhi_q;
    cap_hi_d = 1'b0;
    cmp_d    = 1'b0;
    cnt_d    = cnt_q;
    tot_d    = tot_q;
    valid_d  = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ptr_q;
    ram_raddr = ptr_q;

    // Compare works on the data read at the previous cycle's address.
    if (cmp_q && (ram_rdata > vmin) && (ram_rdata < vmax)) begin
      cnt_d = cnt_q + CountW'(1);
    end

    case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (ptr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          lo_d    = AW'(p_lo);
          hi_d    = AW'(p_hi);
          cnt_d   = '0;
          state_d = in_range ? S_RDLO : S_RESP;
        end
      end
      S_RDLO: begin
        ram_raddr = lo_q;
        state_d   = S_RDHI;
      end
      S_RDHI: begin
        ram_raddr = hi_q;
        vlo_d     = ram_rdata;
        cap_hi_d  = 1'b1;
        ptr_d     = lo_q + AW'(1);
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (ptr_q < hi_q) begin
          cmp_d = 1'b1;
          ptr_d = ptr_q + AW'(1);
        end else begin
          state_d = S_SWAP1;
        end
      end
      S_SWAP1: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = vhi_q;
        state_d   = S_SWAP2;
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = vlo_q;
        tot_d     = lo_lt_hi ? (tot_q + step) : (tot_q - step);
        valid_d   = 1'b1;
        state_d   = S_IDLE;
      end
      S_RESP: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      ptr_q    <= '0;
      cap_hi_q <= 1'b0;
      cmp_q    <= 1'b0;
      tot_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      cap_hi_q <= cap_hi_d;
      cmp_q    <= cmp_d;
      tot_q    <= tot_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    vlo_q <= vlo_d;
    vhi_q <= vhi_d;
    cnt_q <= cnt_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = valid_q;
  assign inversion_total_o = tot_q;
endmodule

>>> rtl/sit_ram.sv
`timescale 1ns / 1ps
module sit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/sit_checker.sv
`timescale 1ns / 1ps
`include "swap_inversion_tracker_macros.svh"
module sit_sva
  import sit_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [PosW-1:0]   first_position_i,
  input logic [PosW-1:0]   second_position_i,
  input logic              result_valid_o,
  input logic [CountW-1:0] inversion_total_o
);
  // An accepted item keeps the block busy in the next cycle.
  `SIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result shows only as the block drops busy.
  `SIT_ASSERT_NOW(a_result_on_fall, result_valid_o, !busy && $past(busy))
  // One strobe per item.
  `SIT_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o)
  // The count moves only with a result.
  `SIT_ASSERT_NOW(a_total_stable, !result_valid_o && $past(!result_valid_o),
                  $stable(inversion_total_o))
endmodule

bind swap_inversion_tracker sit_sva u_sit_sva (.*);

>>> dv/sit_checker.sv
`timescale 1ns / 1ps
module sit_checker
  import sit_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [PosW-1:0]   first_pos_i,
  input  logic [PosW-1:0]   second_pos_i,
  input  logic              res_valid_i,
  input  logic [CountW-1:0] res_total_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o
);

  // Shadow permutation and running count.
  logic [PosW-1:0]   perm_q [DEPTH];
  logic [CountW-1:0] inversions_q;
  logic [CountW-1:0] totals_due [$];

  // Applies one swap to the shadow state, returns the count afterwards.
  function automatic logic [CountW-1:0] swap_and_count(input logic [PosW-1:0] p,
                                                      input logic [PosW-1:0] q);
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       between;
    logic [PosW-1:0]   v_lo;
    logic [PosW-1:0]   v_hi;
    logic [PosW-1:0]   v_min;
    logic [PosW-1:0]   v_max;
    logic [CountW-1:0] delta;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    if (lo != hi && hi < DEPTH) begin
      v_lo    = perm_q[lo];
      v_hi    = perm_q[hi];
      v_min   = (v_lo < v_hi) ? v_lo : v_hi;
      v_max   = (v_lo < v_hi) ? v_hi : v_lo;
      between = 0;
      for (int unsigned i = lo + 1; i < hi; i++) begin
        if (perm_q[i] > v_min && perm_q[i] < v_max) between++;
      end
      delta = CountW'(2 * between + 1);
      if (v_lo < v_hi) begin
        inversions_q = inversions_q + delta;
      end else begin
        inversions_q = inversions_q - delta;
      end
      perm_q[lo] = v_hi;
      perm_q[hi] = v_lo;
    end
    return inversions_q;
  endfunction

  task automatic note_error(input string what, input logic [CountW-1:0] want,
                            input logic [CountW-1:0] got);
    if (error_count_o < 10) begin
      $display("%0t sit_checker: %s: expected %0d, got %0d", $time, what, want, got);
    end
    error_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [CountW-1:0] due;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DEPTH; i++) perm_q[i] = PosW'(i);
      inversions_q = '0;
      totals_due.delete();
      error_count_o = 0;
    end else begin
      // Strobe belongs to an older item, so retire it before taking a new one.
      if (res_valid_i) begin
        if (totals_due.size() == 0) begin
          note_error("result with no item outstanding", '0, res_total_i);
        end else begin
          due = totals_due.pop_front();
          if (res_total_i !== due) note_error("inversion_total", due, res_total_i);
        end
      end
      if (start_i && !busy_i) begin
        totals_due.push_back(swap_and_count(first_pos_i, second_pos_i));
      end
    end
    pending_o = totals_due.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sit_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [PosW-1:0]   first_pos;
  logic [PosW-1:0]   second_pos;
  logic              result_valid;
  logic [CountW-1:0] inversion_total;
  int unsigned       error_count;
  int unsigned       pending;

  localparam int unsigned RandomItems = 580;
  // Random items in this window go back to back, no idle cycles at all.
  localparam int unsigned BurstFirst  = 250;
  localparam int unsigned BurstLast   = 380;

  swap_inversion_tracker #(
    .DEPTH(DefDepth)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .first_position_i (first_pos),
    .second_position_i(second_pos),
    .result_valid_o   (result_valid),
    .inversion_total_o(inversion_total)
  );

  // Shadow model and scoreboard; only hands back counts.
  sit_checker #(
    .DEPTH(DefDepth)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .first_pos_i  (first_pos),
    .second_pos_i (second_pos),
    .res_valid_i  (result_valid),
    .res_total_i  (inversion_total),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Worst case is roughly fill pass + ~600 items at full-span latency; the
  // timeout allows several times that.
  initial begin
    #30_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Called in the time step of a rising edge. Holds start high until the
  // item is taken; busy read right after the edge is its pre-edge value.
  task automatic send_swap(input logic [PosW-1:0] p, input logic [PosW-1:0] q);
    first_pos  <= p;
    second_pos <= q;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Optional idle after an accept. Short gaps land near the accept, long
  // ones reach into the scan of longer swaps or past the strobe.
  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(99) < 24) begin
      start <= 1'b0;
      if ($urandom_range(99) < 70) begin
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(4, 40)) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned sel;
    int unsigned p;
    int unsigned q;
    int unsigned d;
    start      <= 1'b0;
    first_pos  <= '0;
    second_pos <= '0;
    rst_ni     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The fill pass holds busy; send_swap simply waits it out.
    @(posedge clk_i);

    // Directed: full span both ways (count up then back to zero)
    send_swap(10'd0, 10'd1023);    maybe_idle(1'b1);
    send_swap(10'd1023, 10'd0);    maybe_idle(1'b1);
    // adjacent, then undone with the operands reversed
    send_swap(10'd0, 10'd1);       maybe_idle(1'b1);
    send_swap(10'd1, 10'd0);       maybe_idle(1'b1);
    // equal positions: no change, includes both field extremes
    send_swap(10'd0, 10'd0);       maybe_idle(1'b1);
    send_swap(10'd1023, 10'd1023); maybe_idle(1'b1);
    send_swap(10'd341, 10'd341);   maybe_idle(1'b1);
    // top end adjacent, middle pair, alternating bit patterns
    send_swap(10'd1022, 10'd1023); maybe_idle(1'b1);
    send_swap(10'd512, 10'd511);   maybe_idle(1'b1);
    send_swap(10'd682, 10'd341);   maybe_idle(1'b1);
    // nested full-range swaps: count climbs, then a decrease through them
    send_swap(10'd0, 10'd1023);    maybe_idle(1'b1);
    send_swap(10'd1, 10'd1022);    maybe_idle(1'b1);
    send_swap(10'd1000, 10'd3);    maybe_idle(1'b1);
    send_swap(10'd1022, 10'd1);    maybe_idle(1'b1);
    send_swap(10'd3, 10'd1000);    maybe_idle(1'b1);
    send_swap(10'd1023, 10'd0);    maybe_idle(1'b1);
    // back to back with no idle
    send_swap(10'd7, 10'd9);       maybe_idle(1'b0);
    send_swap(10'd9, 10'd7);       maybe_idle(1'b0);
    send_swap(10'd1023, 10'd512);  maybe_idle(1'b1);
    send_swap(10'd512, 10'd1023);  maybe_idle(1'b1);

    // Random: mostly short spans so the scan stays cheap; a few long ones.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        p = $urandom_range(1023);
        d = $urandom_range(1, 12);
        q = (p + d > 1023) ? p - d : p + d;
      end else if (sel < 67) begin
        p = $urandom_range(1023);
        q = $urandom_range(1023);
      end else if (sel < 77) begin
        p = $urandom_range(1023);
        q = p;
      end else if (sel < 95) begin
        // near one end of the store
        d = $urandom_range(0, 16);
        if ($urandom_range(1) == 1) begin
          p = 1023;
          q = 1023 - d;
        end else begin
          p = 0;
          q = d;
        end
      end else begin
        p = 0;
        q = 1023;
      end
      if ($urandom_range(1) == 1) begin
        d = p;
        p = q;
        q = d;
      end
      send_swap(PosW'(p), PosW'(q));
      maybe_idle(!(n >= BurstFirst && n <= BurstLast));
    end
    start <= 1'b0;

    // Drain, then wait longer than a full-span item to catch stray strobes.
    do @(negedge clk_i); while (pending != 0);
    repeat (DefDepth + 8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_ram.sv
rtl/swap_inversion_tracker.sv
rtl/sit_checker.sv
dv/sit_checker.sv
dv/tb_top.sv
